@@ design/uapc_pkg.sv @@
// Package with the types and match strings of the user-agent platform classifier.
package uapc_pkg;

  localparam int unsigned TailDepth   = 14;
  localparam int unsigned MinTotalLen = 6;
  localparam int unsigned MinTailLen  = 3;

  localparam logic [7:0] OpenParen = 8'h28;

  localparam logic [14*8-1:0] PatAndroid = "Linux; Android";
  localparam logic [2*8-1:0]  PatIp      = "iP";
  localparam logic [4*8-1:0]  PatHone    = "hone";
  localparam logic [2*8-1:0]  PatAd      = "ad";
  localparam logic [2*8-1:0]  PatOd      = "od";
  localparam logic [8*8-1:0]  PatWindows = "Windows ";
  localparam logic [2*8-1:0]  PatNt      = "NT";
  localparam logic [5*8-1:0]  PatPhone   = "Phone";
  localparam logic [9*8-1:0]  PatMac     = "Macintosh";
  localparam logic [3*8-1:0]  PatX11     = "X11";
  localparam logic [6*8-1:0]  PatCros    = "; CrOS";

  typedef enum logic [3:0] {
    DevUnknown  = 4'd0,
    DevAndroid  = 4'd1,
    DevIphone   = 4'd2,
    DevIpad     = 4'd3,
    DevIpod     = 4'd4,
    DevWindows  = 4'd5,
    DevWinPhone = 4'd6,
    DevMac      = 4'd7,
    DevChromeos = 4'd8,
    DevLinux    = 4'd9
  } dev_class_e;

  typedef enum logic [2:0] {
    OsUnknown  = 3'd0,
    OsAndroid  = 3'd1,
    OsIos      = 3'd2,
    OsWindows  = 3'd3,
    OsMac      = 3'd4,
    OsChromeos = 3'd5,
    OsLinux    = 3'd6
  } os_class_e;

  // Packs so that device_class sits in the lowest bits.
  typedef struct packed {
    logic       is_mobile;
    os_class_e  os_class;
    dev_class_e device_class;
  } class_res_t;

  typedef logic [7:0] tail_arr_t [TailDepth];

endpackage

@@ design/user_agent_platform_classifier_core.sv @@
// User-agent platform classifier: byte stream in, one class item per string out.
//
// Bytes of a user-agent string enter on the slave stream, one item per cycle,
// with s_axis_tlast on the final byte. Every accepted byte goes into an input
// register and from there updates the length count, the parenthesis
// flag and the captured tail. On the final byte the classification is worked
// out from the updated tail and stored in the output register, so a result
// item appears on the master stream once its last byte has passed through
// the input and output registers in turn. Non-final bytes produce nothing.
// Throughput is one byte per cycle; strings may follow each other with no gap.
// If the receiver stalls, a final byte waits in the input register until the
// output register is free; s_axis_tready drops only then, and ordinary bytes
// keep flowing behind a waiting result until the next final byte arrives.
// Reset clears all valid flags and counters; the string in progress is lost.
// After each result the counters return to zero for the next string.
module user_agent_platform_classifier_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [3:0] device_class, [6:4] os_class, [7] is_mobile
);
  import uapc_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       in_go, out_free, in_take;

  logic [2:0]  total_q, total_d, total_upd;
  logic        paren_q, paren_d, paren_upd;
  logic [3:0]  tcnt_q, tcnt_d, tcnt_upd;
  tail_arr_t   tail_q, tail_upd;
  logic        tail_we;

  logic       out_vld_q, out_vld_d;
  class_res_t out_res_q, res_c;

  // True if the tail holds the len bytes of pat starting at offset off.
  function automatic logic has_at(input tail_arr_t tail, input logic [3:0] cnt,
                                  input logic [3:0] off, input logic [14*8-1:0] pat,
                                  input logic [3:0] len);
    logic       ok;
    logic [4:0] idx;
    ok = ({1'b0, off} + {1'b0, len}) <= {1'b0, cnt};
    for (int i = 0; i < TailDepth; i++) begin
      idx = {1'b0, off} + 5'(i);
      if ((4'(i) < len) && (idx < 5'(TailDepth))) begin
        if (tail[idx[3:0]] != pat[8*(len-1-4'(i)) +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign out_free      = !out_vld_q || m_axis_tready;
  assign in_go         = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_vld_q || in_go;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = in_take ? 1'b1 : (in_go ? 1'b0 : in_vld_q);

  // State as it stands after the byte in the input register.
  always_comb begin
    total_upd = (total_q < 3'(MinTotalLen)) ? total_q + 3'd1 : total_q;
    paren_upd = paren_q;
    tcnt_upd  = tcnt_q;
    tail_upd  = tail_q;
    tail_we   = 1'b0;
    if (paren_q) begin
      if (tcnt_q < 4'(TailDepth)) begin
        tail_upd[tcnt_q] = in_byte_q;
        tcnt_upd         = tcnt_q + 4'd1;
        tail_we          = 1'b1;
      end
    end else if (in_byte_q == OpenParen) begin
      paren_upd = 1'b1;
    end
  end

  always_comb begin
    total_d = total_q;
    paren_d = paren_q;
    tcnt_d  = tcnt_q;
    if (in_go) begin
      if (in_last_q) begin
        total_d = '0;
        paren_d = 1'b0;
        tcnt_d  = '0;
      end else begin
        total_d = total_upd;
        paren_d = paren_upd;
        tcnt_d  = tcnt_upd;
      end
    end
  end

  always_comb begin
    res_c = '{is_mobile: 1'b0, os_class: OsUnknown, device_class: DevUnknown};
    if ((total_upd >= 3'(MinTotalLen)) && paren_upd && (tcnt_upd >= 4'(MinTailLen))) begin
      if (has_at(tail_upd, tcnt_upd, 4'd0, 112'(PatAndroid), 4'd14)) begin
        res_c = '{1'b1, OsAndroid, DevAndroid};
      end else if (has_at(tail_upd, tcnt_upd, 4'd0, 112'(PatIp), 4'd2)) begin
        if (has_at(tail_upd, tcnt_upd, 4'd2, 112'(PatHone), 4'd4)) begin
          res_c = '{1'b1, OsIos, DevIphone};
        end else if (has_at(tail_upd, tcnt_upd, 4'd2, 112'(PatAd), 4'd2)) begin
          res_c = '{1'b1, OsIos, DevIpad};
        end else if (has_at(tail_upd, tcnt_upd, 4'd2, 112'(PatOd), 4'd2)) begin
          res_c = '{1'b1, OsIos, DevIpod};
        end
      end else if (has_at(tail_upd, tcnt_upd, 4'd0, 112'(PatWindows), 4'd8)) begin
        if (has_at(tail_upd, tcnt_upd, 4'd8, 112'(PatNt), 4'd2)) begin
          res_c = '{1'b0, OsWindows, DevWindows};
        end else if (has_at(tail_upd, tcnt_upd, 4'd8, 112'(PatPhone), 4'd5)) begin
          res_c = '{1'b1, OsWindows, DevWinPhone};
        end
      end else if (has_at(tail_upd, tcnt_upd, 4'd0, 112'(PatMac), 4'd9)) begin
        res_c = '{1'b0, OsMac, DevMac};
      end else if (has_at(tail_upd, tcnt_upd, 4'd0, 112'(PatX11), 4'd3)) begin
        if (has_at(tail_upd, tcnt_upd, 4'd3, 112'(PatCros), 4'd6)) begin
          res_c = '{1'b0, OsChromeos, DevChromeos};
        end else begin
          res_c = '{1'b0, OsLinux, DevLinux};
        end
      end
    end
  end

  assign out_vld_d = (in_go && in_last_q) ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      total_q   <= '0;
      paren_q   <= 1'b0;
      tcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      total_q   <= total_d;
      paren_q   <= paren_d;
      tcnt_q    <= tcnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (in_go && tail_we) begin
      tail_q <= tail_upd;
    end
    if (in_go && in_last_q) begin
      out_res_q <= res_c;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_res_q;

endmodule
